[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables the check.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition that must never be seen while out of reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

[rtl/lpht_pkg.sv]
`default_nettype none

package lpht_pkg;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned SLOT_W      = $clog2(CAPACITY);
  localparam int unsigned SIZE_W      = SLOT_W + 1;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_RESET   = 23;
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OUT_SLOT_W  = 10;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned ENTRY_W     = 1 + KEY_W + DATA_W;

  // remainder unit: DIV_BITS quotient bits retired per cycle
  localparam int unsigned DIV_BITS    = 4;
  localparam int unsigned DIV_CYCLES  = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_PAD_W   = DIV_CYCLES * DIV_BITS;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_CYCLES);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef struct packed {
    logic    clear_we;
    logic    load;
    logic    div_step;
    logic    advance;
    logic    ins_write;
    logic    finish;
    logic    hit;
    status_t code;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic lookup;
    logic table_full;
    logic slot_empty;
    logic key_match;
    logic probe_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/linear_probe_hash_table.sv]
// Open-addressing hash table with linear probing.
// Input stream s_axis: tuser selects insert (0) or lookup (1); tdata carries
// the key and the payload word. Output stream m_axis: tuser is the status
// (inserted, full, found, not found); tdata carries the slot and found data.
// cfg_we/cfg_wdata set the table size; write it only while the block is idle.
// Each transaction gives exactly one result transaction.
// Timing: the home slot comes from a remainder unit (4 bits per cycle), then
// each probe reads the table (one table read port, registered read) and
// checks the entry. The next item is taken only after the result has moved
// into the output register. A full insert reports at the first probe check.
// Reset: rst clears the fill count, sets the size to 23 and starts a
// clearing pass over all 1024 slots, one per cycle; s_axis_tready stays low
// until that pass is done.
// Stall: a result waits in the output register while m_axis_tready is low;
// the next item is accepted meanwhile and finishes once that register frees.
`default_nettype none

module linear_probe_hash_table (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [10:0] cfg_wdata,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // key[30:0], entry_data[62:31], zero
  input  wire         s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // slot[9:0], found_data[41:10], zero
  output logic [1:0]  m_axis_tuser    // status
);

  localparam int unsigned KEY_W  = lpht_pkg::KEY_W;
  localparam int unsigned DATA_W = lpht_pkg::DATA_W;
  localparam int unsigned OSW    = lpht_pkg::OUT_SLOT_W;

  lpht_pkg::ctrl_cmd_t  cmd;
  lpht_pkg::dp_status_t st;
  lpht_pkg::status_t    out_status;
  logic [OSW-1:0]       out_slot;
  logic [DATA_W-1:0]    out_data;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lpht_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_kind    (s_axis_tuser),
    .in_key     (s_axis_tdata[KEY_W-1:0]),
    .in_data    (s_axis_tdata[KEY_W +: DATA_W]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_data   (out_data),
    .cmd        (cmd),
    .st         (st)
  );

  assign m_axis_tdata = {(lpht_pkg::OUT_TDATA_W - OSW - DATA_W)'(0), out_data, out_slot};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

[rtl/lpht_ctrl.sv]
`default_nettype none

module lpht_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  lpht_pkg::dp_status_t st,
  output lpht_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.code   = lpht_pkg::ST_INSERTED;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        // wait for the registered table read
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!st.lookup) begin
          priority if (st.table_full) begin
            cmd.finish = 1'b1;
            cmd.code   = lpht_pkg::ST_FULL;
          end else if (st.slot_empty) begin
            cmd.ins_write = 1'b1;
            cmd.finish    = 1'b1;
            cmd.hit       = 1'b1;
            cmd.code      = lpht_pkg::ST_INSERTED;
          end else if (st.probe_last) begin
            cmd.finish = 1'b1;
            cmd.code   = lpht_pkg::ST_FULL;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          priority if (st.slot_empty) begin
            cmd.finish = 1'b1;
            cmd.code   = lpht_pkg::ST_MISSING;
          end else if (st.key_match) begin
            cmd.finish = 1'b1;
            cmd.hit    = 1'b1;
            cmd.code   = lpht_pkg::ST_FOUND;
          end else if (st.probe_last) begin
            cmd.finish = 1'b1;
            cmd.code   = lpht_pkg::ST_MISSING;
          end else begin
            cmd.advance = 1'b1;
          end
        end
        state_next = cmd.finish ? S_OUT : S_READ;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/lpht_dp.sv]
`default_nettype none

module lpht_dp (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     cfg_we,
  input  wire  [lpht_pkg::CFG_W-1:0]              cfg_wdata,
  input  wire                                     in_kind,
  input  wire  [lpht_pkg::KEY_W-1:0]              in_key,
  input  wire  [lpht_pkg::DATA_W-1:0]             in_data,
  input  wire                                     out_ready,
  output logic                                    out_valid,
  output lpht_pkg::status_t                       out_status,
  output logic [lpht_pkg::OUT_SLOT_W-1:0]         out_slot,
  output logic [lpht_pkg::DATA_W-1:0]             out_data,
  input  lpht_pkg::ctrl_cmd_t                     cmd,
  output lpht_pkg::dp_status_t                    st
);

  localparam int unsigned SLOT_W    = lpht_pkg::SLOT_W;
  localparam int unsigned SIZE_W    = lpht_pkg::SIZE_W;
  localparam int unsigned CFG_W     = lpht_pkg::CFG_W;
  localparam int unsigned KEY_W     = lpht_pkg::KEY_W;
  localparam int unsigned DATA_W    = lpht_pkg::DATA_W;
  localparam int unsigned ENTRY_W   = lpht_pkg::ENTRY_W;
  localparam int unsigned DIV_BITS  = lpht_pkg::DIV_BITS;
  localparam int unsigned DIV_PAD_W = lpht_pkg::DIV_PAD_W;
  localparam int unsigned DIV_CNT_W = lpht_pkg::DIV_CNT_W;
  localparam int unsigned CMP_W     = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w == '0) begin
      return SIZE_W'(1);
    end else if (w > CMP_W'(lpht_pkg::CAPACITY)) begin
      return SIZE_W'(lpht_pkg::CAPACITY);
    end else begin
      return SIZE_W'(w);
    end
  endfunction

  // table: {valid, key, data} per slot
  logic [ENTRY_W-1:0] mem [lpht_pkg::CAPACITY];
  logic [ENTRY_W-1:0] rd_entry;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_entry;
  logic               wr_en;

  logic [SIZE_W-1:0]    size;
  logic [SIZE_W-1:0]    fill;
  lpht_pkg::kind_t      kind;
  logic [KEY_W-1:0]     key;
  logic [DATA_W-1:0]    data;
  logic [DIV_PAD_W-1:0] div_sh;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SLOT_W-1:0]    pos;
  logic [SLOT_W-1:0]    pos_next;
  logic [SIZE_W-1:0]    pos_inc;
  logic [SIZE_W-1:0]    probe_cnt;
  logic [SLOT_W-1:0]    clr_cnt;
  lpht_pkg::status_t    res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [DATA_W-1:0]    res_data;

  logic               rd_valid;
  logic [KEY_W-1:0]   rd_key;
  logic [DATA_W-1:0]  rd_data;

  assign rd_valid = rd_entry[ENTRY_W-1];
  assign rd_key   = rd_entry[DATA_W +: KEY_W];
  assign rd_data  = rd_entry[DATA_W-1:0];

  // DIV_BITS restoring steps per cycle; the remainder stays below the table size
  always_comb begin
    logic [SIZE_W:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[SIZE_W-1:0], div_sh[DIV_PAD_W-1-i]};
      if (r >= {1'b0, size}) begin
        r = r - {1'b0, size};
      end
    end
    rem_next = r[SIZE_W-1:0];
  end

  assign pos_inc  = {1'b0, pos} + SIZE_W'(1);
  assign pos_next = (pos_inc == size) ? '0 : pos_inc[SLOT_W-1:0];

  assign st.clear_last = (clr_cnt == SLOT_W'(lpht_pkg::CAPACITY - 1));
  assign st.div_last   = (div_cnt == DIV_CNT_W'(lpht_pkg::DIV_CYCLES - 1));
  assign st.lookup     = (kind == lpht_pkg::KIND_LOOKUP);
  assign st.table_full = (fill >= size);
  assign st.slot_empty = !rd_valid;
  assign st.key_match  = rd_valid && (rd_key == key);
  assign st.probe_last = ((probe_cnt + SIZE_W'(1)) == size);
  assign st.out_free   = !out_valid || out_ready;

  assign wr_en    = cmd.clear_we || cmd.ins_write;
  assign wr_addr  = cmd.clear_we ? clr_cnt : pos;
  assign wr_entry = cmd.clear_we ? '0 : {1'b1, key, data};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= clamp_size(CFG_W'(lpht_pkg::CFG_RESET));
      fill    <= '0;
      clr_cnt <= '0;
    end else begin
      if (cfg_we) begin
        size <= clamp_size(cfg_wdata);
      end
      if (cmd.ins_write) begin
        fill <= fill + SIZE_W'(1);
      end
      if (cmd.clear_we) begin
        clr_cnt <= clr_cnt + SLOT_W'(1);
      end
    end
  end

  // operand capture, remainder, probe walk and result capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= lpht_pkg::kind_t'(in_kind);
      key     <= in_key;
      data    <= in_data;
      div_sh  <= DIV_PAD_W'(in_key);
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_sh  <= div_sh << DIV_BITS;
      rem     <= rem_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (st.div_last) begin
        pos       <= rem_next[SLOT_W-1:0];
        probe_cnt <= '0;
      end
    end
    if (cmd.advance) begin
      pos       <= pos_next;
      probe_cnt <= probe_cnt + SIZE_W'(1);
    end
    if (cmd.finish) begin
      res_status <= cmd.code;
      res_slot   <= cmd.hit ? pos : '0;
      res_data   <= (cmd.code == lpht_pkg::ST_FOUND) ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= lpht_pkg::OUT_SLOT_W'(res_slot);
      out_data   <= res_data;
    end
  end

endmodule

`default_nettype wire

[rtl/lpht_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module lpht_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [47:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);

  // one item in flight: ready drops right after an accept
  `ASSERT_PROP(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready stayed high after accept")

  `ASSERT_PROP(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `ASSERT_NEVER(a_miss_zero, clk, rst, m_axis_tvalid && (m_axis_tuser == lpht_pkg::ST_FULL || m_axis_tuser == lpht_pkg::ST_MISSING) && m_axis_tdata != 48'd0, "full or miss result carries slot or data")

  `ASSERT_NEVER(a_insert_no_data, clk, rst, m_axis_tvalid && m_axis_tuser == lpht_pkg::ST_INSERTED && m_axis_tdata[41:10] != 32'd0, "insert result carries data")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
